FILE: rtl/lds_pkg.sv
// ---------------------------------------------------------------------------
// lds_pkg
// Shared types and constants for the discrete inverted pendulum step block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lds_pkg;

  localparam int DATA_W         = 32;
  localparam int AXIS_W         = 2;
  localparam int STEP_TIME_W    = 31;
  localparam int REG_INDEX_W    = 3;
  localparam int COEF_FRAC_BITS = 28;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [REG_INDEX_W-1:0] REG_COSH_TERM      = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SINH_OVER_ETA  = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_ONE_MINUS_COSH = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_ETA_SINH       = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_POS_DRIVE_COEF = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_STEP_TIME      = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_HEIGHT_OFFSET  = 3'd6;

  localparam logic signed [DATA_W-1:0] COSH_RESET = 32'sh1000_0000;
  localparam logic signed [DATA_W-1:0] SAT_MAX    = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN    = 32'sh8000_0000;

  typedef struct packed {
    logic [AXIS_W-1:0]        axis;
    logic signed [DATA_W-1:0] com_pos;
    logic signed [DATA_W-1:0] com_vel;
    logic signed [DATA_W-1:0] zmp_pos;
    logic signed [DATA_W-1:0] zmp_rate;
    logic signed [DATA_W-1:0] dist_pos;
    logic signed [DATA_W-1:0] dist_vel;
    logic signed [DATA_W-1:0] dist_zmp;
  } in_word_t;

  typedef struct packed {
    logic [AXIS_W-1:0]        axis_out;
    logic signed [DATA_W-1:0] next_pos;
    logic signed [DATA_W-1:0] next_vel;
    logic signed [DATA_W-1:0] next_zmp;
  } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/lds_in_if.sv
// ---------------------------------------------------------------------------
// lds_in_if
// Valid/ready channel carrying one axis state word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lds_in_if;
  logic              valid;
  logic              ready;
  lds_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lds_out_if.sv
// ---------------------------------------------------------------------------
// lds_out_if
// Valid/ready channel carrying one next-state word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lds_out_if;
  logic               valid;
  logic               ready;
  lds_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lip_discrete_state_step.sv
// ---------------------------------------------------------------------------
// lip_discrete_state_step
// One discrete step of a linear inverted pendulum, one axis per word.
//
//   channel  dir  handshake       payload
//   din      in   valid/ready     axis, com/zmp state, zmp rate, disturbance
//   dout     out  valid/ready     axis_out, next_pos, next_vel, next_zmp
//   cfg      in   wr_en only      wr_index, wr_data
//
// five register stages: input, zmp offset, products, row sums, corrections
// one word per cycle unless dout stalls; dout.valid is the last stage's valid
// the whole pipe advances when dout is empty or taken; din.ready follows it
// synchronous reset clears stage valids and loads the coefficient defaults
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lip_discrete_state_step #(
  parameter int COEF_FRAC_BITS = lds_pkg::COEF_FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  lds_in_if.sink                                  din,
  lds_out_if.source                               dout,
  input  wire logic                               wr_en,
  input  wire logic [lds_pkg::REG_INDEX_W-1:0]    wr_index,
  input  wire logic [lds_pkg::DATA_W-1:0]         wr_data
);

  localparam int DW = lds_pkg::DATA_W;
  localparam int PW = 2 * DW;
  localparam int TW = PW - COEF_FRAC_BITS;
  localparam int SW = TW + 3;

  function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] x);
    logic [SW-DW:0] top;
    top = x[SW-1:DW-1];
    if (top == '0 || top == '1) begin
      return x[DW-1:0];
    end else if (x[SW-1]) begin
      return lds_pkg::SAT_MIN;
    end else begin
      return lds_pkg::SAT_MAX;
    end
  endfunction

  function automatic logic signed [TW-1:0] cmul(input logic signed [DW-1:0] c,
                                                 input logic signed [DW-1:0] s);
    logic signed [PW-1:0] prod;
    prod = PW'(c) * PW'(s);
    return prod[PW-1:COEF_FRAC_BITS];
  endfunction

  // configuration
  logic signed [DW-1:0]                  cosh_term;
  logic signed [DW-1:0]                  sinh_over_eta;
  logic signed [DW-1:0]                  one_minus_cosh;
  logic signed [DW-1:0]                  eta_sinh;
  logic signed [DW-1:0]                  pos_drive_coef;
  logic [lds_pkg::STEP_TIME_W-1:0]       step_time;
  logic signed [DW-1:0]                  height_offset;
  logic signed [DW-1:0]                  dt;

  // stage valids
  logic v0, v1, v2, v3, v4;
  logic adv;

  // stage 0
  lds_pkg::in_word_t s0;

  // stage 1
  logic [lds_pkg::AXIS_W-1:0] s1_axis;
  logic signed [DW-1:0] s1_p, s1_v, s1_zo, s1_u, s1_d0, s1_d1, s1_d2;
  logic signed [DW-1:0] zo_next;

  // stage 2
  logic [lds_pkg::AXIS_W-1:0] s2_axis;
  logic signed [DW-1:0] s2_zo;
  logic signed [TW-1:0] t_cp, t_sv, t_mz, t_du, t_ep, t_cv, t_ez, t_mu, t_tu;
  logic signed [TW-1:0] t_d0, t_d1, t_d2;

  // stage 3
  logic [lds_pkg::AXIS_W-1:0] s3_axis;
  logic signed [DW-1:0] s3_np, s3_nv, s3_nz;
  logic signed [TW-1:0] s3_d0, s3_d1, s3_d2;
  logic signed [DW-1:0] np_next, nv_next, nz_next;

  // stage 4
  lds_pkg::out_word_t s4;
  lds_pkg::out_word_t s4_next;

  assign adv        = !v4 || dout.ready;
  assign din.ready  = adv;
  assign dout.valid = v4;
  assign dout.data  = s4;
  assign dt         = DW'({1'b0, step_time});

  always_ff @(posedge clk) begin
    if (rst) begin
      v0             <= 1'b0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      v4             <= 1'b0;
      cosh_term      <= lds_pkg::COSH_RESET;
      sinh_over_eta  <= '0;
      one_minus_cosh <= '0;
      eta_sinh       <= '0;
      pos_drive_coef <= '0;
      step_time      <= '0;
      height_offset  <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          lds_pkg::REG_COSH_TERM:      cosh_term      <= wr_data;
          lds_pkg::REG_SINH_OVER_ETA:  sinh_over_eta  <= wr_data;
          lds_pkg::REG_ONE_MINUS_COSH: one_minus_cosh <= wr_data;
          lds_pkg::REG_ETA_SINH:       eta_sinh       <= wr_data;
          lds_pkg::REG_POS_DRIVE_COEF: pos_drive_coef <= wr_data;
          lds_pkg::REG_STEP_TIME:      step_time      <= wr_data[lds_pkg::STEP_TIME_W-1:0];
          lds_pkg::REG_HEIGHT_OFFSET:  height_offset  <= wr_data;
          default: ;
        endcase
      end
      if (adv) begin
        v0 <= din.valid;
        v1 <= v0;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
      end
    end
  end

  // vertical axis works around the target height
  always_comb begin
    if (s0.axis == lds_pkg::AXIS_Z) begin
      zo_next = sat(SW'(s0.zmp_pos) + SW'(height_offset));
    end else begin
      zo_next = s0.zmp_pos;
    end
  end

  always_comb begin
    np_next = sat(SW'(t_cp) + SW'(t_sv) + SW'(t_mz) + SW'(t_du));
    nv_next = sat(SW'(t_ep) + SW'(t_cv) - SW'(t_ez) + SW'(t_mu));
    nz_next = sat(SW'(s2_zo) + SW'(t_tu));
  end

  always_comb begin
    s4_next.axis_out = s3_axis;
    s4_next.next_pos = s3_np;
    s4_next.next_vel = s3_nv;
    s4_next.next_zmp = s3_nz;
    case (s3_axis)
      lds_pkg::AXIS_Y: begin
        s4_next.next_pos = sat(SW'(s3_np) + SW'(s3_d0));
        s4_next.next_vel = sat(SW'(s3_nv) + SW'(s3_d1));
        s4_next.next_zmp = sat(SW'(s3_nz) + SW'(s3_d2));
      end
      lds_pkg::AXIS_Z: begin
        s4_next.next_zmp = sat(SW'(s3_nz) - SW'(height_offset));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0 <= din.data;

      s1_axis <= s0.axis;
      s1_p    <= s0.com_pos;
      s1_v    <= s0.com_vel;
      s1_zo   <= zo_next;
      s1_u    <= s0.zmp_rate;
      s1_d0   <= s0.dist_pos;
      s1_d1   <= s0.dist_vel;
      s1_d2   <= s0.dist_zmp;

      s2_axis <= s1_axis;
      s2_zo   <= s1_zo;
      t_cp    <= cmul(cosh_term, s1_p);
      t_sv    <= cmul(sinh_over_eta, s1_v);
      t_mz    <= cmul(one_minus_cosh, s1_zo);
      t_du    <= cmul(pos_drive_coef, s1_u);
      t_ep    <= cmul(eta_sinh, s1_p);
      t_cv    <= cmul(cosh_term, s1_v);
      t_ez    <= cmul(eta_sinh, s1_zo);
      t_mu    <= cmul(one_minus_cosh, s1_u);
      t_tu    <= cmul(dt, s1_u);
      t_d0    <= cmul(dt, s1_d0);
      t_d1    <= cmul(dt, s1_d1);
      t_d2    <= cmul(dt, s1_d2);

      s3_axis <= s2_axis;
      s3_np   <= np_next;
      s3_nv   <= nv_next;
      s3_nz   <= nz_next;
      s3_d0   <= t_d0;
      s3_d1   <= t_d1;
      s3_d2   <= t_d2;

      s4 <= s4_next;
    end
  end

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> (dout.valid && !dout.ready))
    else $error("din stalled without a blocked result");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && !dout.ready) |=> ($stable({v0, v1, v2, v3, v4}) && $stable(s4)))
    else $error("pipeline moved while result stalled");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |=> v0)
    else $error("accepted word missing from first stage");

  a_accept_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (adv && v3) |=> dout.valid)
    else $error("accepted word lost in pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !dout.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks lip_discrete_state_step against a cycle-free predictor of the
// pendulum step. Words go in on din with random gaps, next-state words are
// taken on dout with random stalls, and each one is compared field by field
// with the oldest prediction. Phases use the reset values, then coefficient
// sets written while the pipe is empty: a realistic set, both extremes and
// random sets. One phase holds dout off long enough to stall din.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int                              PIPE_LATENCY = 5;
  localparam logic [lds_pkg::REG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  logic clk;
  logic rst;
  logic wr_en;
  logic [lds_pkg::REG_INDEX_W-1:0] wr_index;
  logic [lds_pkg::DATA_W-1:0] wr_data;

  lds_in_if  in_ch ();
  lds_out_if out_ch ();

  lip_discrete_state_step dut (
    .clk      (clk),
    .rst      (rst),
    .din      (in_ch),
    .dout     (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // coefficient copy
  logic signed [lds_pkg::DATA_W-1:0] coef_cosh;
  logic signed [lds_pkg::DATA_W-1:0] coef_sinh_eta;
  logic signed [lds_pkg::DATA_W-1:0] coef_one_minus_cosh;
  logic signed [lds_pkg::DATA_W-1:0] coef_eta_sinh;
  logic signed [lds_pkg::DATA_W-1:0] coef_pos_drive;
  logic [lds_pkg::STEP_TIME_W-1:0]   dt_coef;
  logic signed [lds_pkg::DATA_W-1:0] zmp_height;

  lds_pkg::out_word_t expected_steps[$];
  lds_pkg::out_word_t exp_w;
  int                 fail_count = 0;
  bit                 send_idle_on = 1'b1;
  bit                 recv_idle_on = 1'b1;
  int                 hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint coef_times_state(longint coef, longint st);
    return (coef * st) >>> lds_pkg::COEF_FRAC_BITS;
  endfunction

  function automatic logic signed [lds_pkg::DATA_W-1:0] clamp32(longint x);
    if (x > longint'(lds_pkg::SAT_MAX)) return lds_pkg::SAT_MAX;
    if (x < longint'(lds_pkg::SAT_MIN)) return lds_pkg::SAT_MIN;
    return x[lds_pkg::DATA_W-1:0];
  endfunction

  function automatic lds_pkg::out_word_t lip_next_state(lds_pkg::in_word_t w);
    lds_pkg::out_word_t r;
    longint p, v, z, u, c, s, omc, e, pd, dt, h, zo, np, nv, nz;
    p   = longint'($signed(w.com_pos));
    v   = longint'($signed(w.com_vel));
    z   = longint'($signed(w.zmp_pos));
    u   = longint'($signed(w.zmp_rate));
    c   = longint'(coef_cosh);
    s   = longint'(coef_sinh_eta);
    omc = longint'(coef_one_minus_cosh);
    e   = longint'(coef_eta_sinh);
    pd  = longint'(coef_pos_drive);
    dt  = longint'({1'b0, dt_coef});
    h   = longint'(zmp_height);
    zo  = (w.axis == lds_pkg::AXIS_Z) ? longint'(clamp32(z + h)) : z;
    np  = longint'(clamp32(coef_times_state(c, p) + coef_times_state(s, v)
                           + coef_times_state(omc, zo) + coef_times_state(pd, u)));
    nv  = longint'(clamp32(coef_times_state(e, p) + coef_times_state(c, v)
                           - coef_times_state(e, zo) + coef_times_state(omc, u)));
    nz  = longint'(clamp32(zo + coef_times_state(dt, u)));
    if (w.axis == lds_pkg::AXIS_Z) nz = longint'(clamp32(nz - h));
    if (w.axis == lds_pkg::AXIS_Y) begin
      np = longint'(clamp32(np + coef_times_state(dt, longint'($signed(w.dist_pos)))));
      nv = longint'(clamp32(nv + coef_times_state(dt, longint'($signed(w.dist_vel)))));
      nz = longint'(clamp32(nz + coef_times_state(dt, longint'($signed(w.dist_zmp)))));
    end
    r.axis_out = w.axis;
    r.next_pos = np[lds_pkg::DATA_W-1:0];
    r.next_vel = nv[lds_pkg::DATA_W-1:0];
    r.next_zmp = nz[lds_pkg::DATA_W-1:0];
    return r;
  endfunction

  function automatic lds_pkg::in_word_t mk_word(logic [lds_pkg::AXIS_W-1:0] ax,
                                                logic [lds_pkg::DATA_W-1:0] p,
                                                logic [lds_pkg::DATA_W-1:0] v,
                                                logic [lds_pkg::DATA_W-1:0] z,
                                                logic [lds_pkg::DATA_W-1:0] u,
                                                logic [lds_pkg::DATA_W-1:0] dp,
                                                logic [lds_pkg::DATA_W-1:0] dv,
                                                logic [lds_pkg::DATA_W-1:0] dz);
    lds_pkg::in_word_t w;
    w.axis     = ax;
    w.com_pos  = p;
    w.com_vel  = v;
    w.zmp_pos  = z;
    w.zmp_rate = u;
    w.dist_pos = dp;
    w.dist_vel = dv;
    w.dist_zmp = dz;
    return w;
  endfunction

  function automatic logic [lds_pkg::DATA_W-1:0] rand_state_val();
    case ($urandom_range(0, 9))
      0: return lds_pkg::SAT_MAX;
      1: return lds_pkg::SAT_MIN;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [lds_pkg::DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return lds_pkg::SAT_MAX;
      1: return lds_pkg::SAT_MIN;
      2: return '0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endcase
  endfunction

  function automatic lds_pkg::in_word_t rand_word();
    return mk_word(lds_pkg::AXIS_W'($urandom_range(0, 3)), rand_state_val(),
                   rand_state_val(), rand_state_val(), rand_state_val(),
                   rand_state_val(), rand_state_val(), rand_state_val());
  endfunction

  task automatic set_reg(input logic [lds_pkg::REG_INDEX_W-1:0] idx,
                         input logic [lds_pkg::DATA_W-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    case (idx)
      lds_pkg::REG_COSH_TERM:      coef_cosh = val;
      lds_pkg::REG_SINH_OVER_ETA:  coef_sinh_eta = val;
      lds_pkg::REG_ONE_MINUS_COSH: coef_one_minus_cosh = val;
      lds_pkg::REG_ETA_SINH:       coef_eta_sinh = val;
      lds_pkg::REG_POS_DRIVE_COEF: coef_pos_drive = val;
      lds_pkg::REG_STEP_TIME:      dt_coef = val[lds_pkg::STEP_TIME_W-1:0];
      lds_pkg::REG_HEIGHT_OFFSET:  zmp_height = val;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_all_regs(input logic [lds_pkg::DATA_W-1:0] c,
                              input logic [lds_pkg::DATA_W-1:0] s,
                              input logic [lds_pkg::DATA_W-1:0] omc,
                              input logic [lds_pkg::DATA_W-1:0] e,
                              input logic [lds_pkg::DATA_W-1:0] pd,
                              input logic [lds_pkg::DATA_W-1:0] dt,
                              input logic [lds_pkg::DATA_W-1:0] h);
    set_reg(lds_pkg::REG_COSH_TERM, c);
    set_reg(lds_pkg::REG_SINH_OVER_ETA, s);
    set_reg(lds_pkg::REG_ONE_MINUS_COSH, omc);
    set_reg(lds_pkg::REG_ETA_SINH, e);
    set_reg(lds_pkg::REG_POS_DRIVE_COEF, pd);
    set_reg(lds_pkg::REG_STEP_TIME, dt);
    set_reg(lds_pkg::REG_HEIGHT_OFFSET, h);
  endtask

  task automatic send_word(input lds_pkg::in_word_t w);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    expected_steps.push_back(lip_next_state(w));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_steps.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 3) @(negedge clk);
  endtask

  // receiver: per-word stall, long hold when requested
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, 13) : 0;
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic report_field(input string name, input logic [lds_pkg::DATA_W-1:0] e,
                              input logic [lds_pkg::DATA_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, out_ch.data);
        fail_count++;
      end else begin
        exp_w = expected_steps.pop_front();
        report_field("axis_out", lds_pkg::DATA_W'(exp_w.axis_out),
                     lds_pkg::DATA_W'(out_ch.data.axis_out));
        report_field("next_pos", exp_w.next_pos, out_ch.data.next_pos);
        report_field("next_vel", exp_w.next_vel, out_ch.data.next_vel);
        report_field("next_zmp", exp_w.next_zmp, out_ch.data.next_zmp);
      end
    end
  end

  task automatic test_reset_defaults();
    send_word(mk_word(lds_pkg::AXIS_X, 32'h0001_0000, 32'hffff_8000, 32'h0000_4000,
                      32'h0002_0000, 32'h1, 32'h2, 32'h3));
    send_word(mk_word(lds_pkg::AXIS_Y, lds_pkg::SAT_MAX, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MAX, lds_pkg::SAT_MIN, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MAX));
    send_word(mk_word(lds_pkg::AXIS_Z, lds_pkg::SAT_MIN, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MAX, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MAX, lds_pkg::SAT_MIN));
    send_word(mk_word(2'd3, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
  endtask

  task automatic test_realistic_step();
    wait_idle();
    // dt 5 ms, eta about 3.5, height 0.8 m
    set_all_regs(32'd268476571, 32'd1342191, -32'd41115, 32'd16442,
                 -32'd14, 32'd1342177, 32'd52429);
    set_reg(REG_UNMAPPED, 32'hdead_beef);
    send_word(mk_word(lds_pkg::AXIS_X, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000,
                      32'h0000_2000, 32'h0, 32'h0, 32'h0));
    send_word(mk_word(lds_pkg::AXIS_Y, 32'hffff_0000, 32'h0000_1000, 32'hfffe_0000,
                      32'hffff_f000, 32'h0010_0000, 32'hfff0_0000, 32'h0008_0000));
    send_word(mk_word(lds_pkg::AXIS_Z, 32'h0000_0100, 32'hffff_ff00, 32'h0000_0000,
                      32'h0001_0000, 32'h1, 32'h1, 32'h1));
    send_word(mk_word(2'd3, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000,
                      32'h0000_2000, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MAX));
    send_word(mk_word(lds_pkg::AXIS_Y, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MAX, lds_pkg::SAT_MAX));
    send_word(mk_word(lds_pkg::AXIS_Y, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MAX, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MIN));
    send_word(mk_word(lds_pkg::AXIS_X, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'h0, 32'h0, 32'h0));
    send_word(mk_word(lds_pkg::AXIS_Z, 32'h0, 32'h0, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      32'h0, 32'h0, 32'h0));
    send_word(mk_word(lds_pkg::AXIS_Z, 32'h0, 32'h0, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                      32'h0, 32'h0, 32'h0));
    send_word(mk_word(lds_pkg::AXIS_X, 32'h0, 32'h0, 32'h0, lds_pkg::SAT_MIN,
                      32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_extreme_coefficients();
    wait_idle();
    set_all_regs(lds_pkg::SAT_MAX, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                 lds_pkg::SAT_MAX, 32'hffff_ffff, lds_pkg::SAT_MAX);
    send_word(mk_word(lds_pkg::AXIS_Y, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MAX, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MAX, lds_pkg::SAT_MAX));
    send_word(mk_word(lds_pkg::AXIS_Z, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MIN));
    send_word(mk_word(lds_pkg::AXIS_X, lds_pkg::SAT_MAX, lds_pkg::SAT_MIN, 32'h0,
                      32'hffff_ffff, 32'h0, 32'h0, 32'h0));
    wait_idle();
    set_all_regs(lds_pkg::SAT_MIN, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                 lds_pkg::SAT_MIN, 32'h0, lds_pkg::SAT_MIN);
    send_word(mk_word(lds_pkg::AXIS_Y, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MIN, lds_pkg::SAT_MIN,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MIN));
    send_word(mk_word(lds_pkg::AXIS_Z, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MIN, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MAX, lds_pkg::SAT_MAX));
    send_word(mk_word(2'd3, lds_pkg::SAT_MIN, lds_pkg::SAT_MAX, lds_pkg::SAT_MAX,
                      lds_pkg::SAT_MIN, 32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_random_phases();
    logic [lds_pkg::DATA_W-1:0] dt_val;
    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: dt_val = 32'h7fff_ffff;
        1: dt_val = 32'h0;
        2: dt_val = $urandom;
        default: dt_val = $urandom_range(0, 32'h0080_0000);
      endcase
      set_all_regs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   dt_val, rand_state_val());
      set_reg(REG_UNMAPPED, $urandom);
      for (int n = 0; n < 195; n++) begin
        if (n % 50 == 0) begin
          send_idle_on = ($urandom_range(0, 3) != 0);
          recv_idle_on = ($urandom_range(0, 3) != 0);
        end
        send_word(rand_word());
      end
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    hold_request = 150;
    for (int n = 0; n < 40; n++) send_word(rand_word());
    send_idle_on = 1'b1;
  endtask

  initial begin
    rst                 = 1'b1;
    wr_en               = 1'b0;
    wr_index            = '0;
    wr_data             = '0;
    in_ch.valid         = 1'b0;
    in_ch.data          = '0;
    coef_cosh           = lds_pkg::COSH_RESET;
    coef_sinh_eta       = '0;
    coef_one_minus_cosh = '0;
    coef_eta_sinh       = '0;
    coef_pos_drive      = '0;
    dt_coef             = '0;
    zmp_height          = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_realistic_step();
    test_extreme_coefficients();
    test_random_phases();
    test_output_backpressure();
    wait_idle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
